@@ rtl/pwfr_pkg.sv @@
// Shared types, constants and helpers of the pulse width frame receiver.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package pwfr_pkg;

  // Frame store capacity in bits and derived sizes
  localparam int MAX_FRAME_BITS = 64;
  localparam int STORE_BYTES    = (MAX_FRAME_BITS + 7) / 8;
  localparam int BIT_W          = $clog2(MAX_FRAME_BITS + 1);
  localparam int BYTE_W         = $clog2(STORE_BYTES + 1);
  localparam int IDX_W          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_MIN  = 3'd6;

  // Input operation codes
  localparam logic [1:0] OP_FALL = 2'd0;
  localparam logic [1:0] OP_RISE = 2'd1;
  localparam logic [1:0] OP_SOFT = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_SYNCED  = 3'd1;
  localparam logic [2:0] ST_STORED  = 3'd2;
  localparam logic [2:0] ST_DROPPED = 3'd3;
  localparam logic [2:0] ST_BYTE    = 3'd4;
  localparam logic [2:0] ST_ERROR   = 3'd5;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_SYNCED    = 2'd1,
    MODE_RECEIVING = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CMD_SYNC,
    CMD_IGNORE,
    CMD_BIT0,
    CMD_BIT1,
    CMD_STOP,
    CMD_ERROR,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] stamp_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] pulse_width_ms;
    logic [7:0]  data_byte;
    logic [5:0]  byte_index;
    logic [6:0]  byte_total;
    logic [9:0]  bits_held;
    logic [31:0] frames_done;
    logic [31:0] errors_seen;
    logic [1:0]  rx_mode;
    logic        last;
  } out_item_t;

  // Classified pulse handed from front to back
  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] width;
    mode_t       mode;
  } cmd_t;

  // Whole bytes covering a bit count
  function automatic logic [BYTE_W-1:0] bytes_for_bits(input logic [BIT_W-1:0] bits);
    logic [BIT_W:0] s;
    s = {1'b0, bits} + (BIT_W + 1)'(7);
    return BYTE_W'(s >> 3);
  endfunction

endpackage

`default_nettype wire

@@ rtl/pwfr_front.sv @@
// Front end: configuration registers, fall time capture, pulse classification.
// Depends on pwfr_pkg; feeds classified commands to the command queue.
`default_nettype none

module pwfr_front
  import pwfr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire in_item_t             in_item,
  input  wire logic                 cfg_wr,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  output logic                      cmd_wr,
  output cmd_t                      cmd_data
);

  logic [15:0] sync_min, sync_max, zero_min, zero_max;
  logic [15:0] one_min, one_limit, stop_min;
  logic [31:0] fall_stamp;
  mode_t       mode;

  logic [31:0] width;
  logic        is_sync, is_zero, is_one, is_stop;
  cmd_kind_t   kind;
  mode_t       mode_after;

  assign width   = in_item.stamp_ms - fall_stamp;
  assign is_sync = (width >= 32'(sync_min)) && (width <= 32'(sync_max));
  assign is_zero = (width >= 32'(zero_min)) && (width <= 32'(zero_max));
  assign is_one  = (width >= 32'(one_min)) && (width < 32'(one_limit));
  assign is_stop = (width >= 32'(stop_min));

  // First matching class wins
  always_comb begin
    priority if (is_sync) begin
      kind       = CMD_SYNC;
      mode_after = MODE_SYNCED;
    end else if (mode == MODE_IDLE) begin
      kind       = CMD_IGNORE;
      mode_after = MODE_IDLE;
    end else if (is_zero) begin
      kind       = CMD_BIT0;
      mode_after = MODE_RECEIVING;
    end else if (is_one) begin
      kind       = CMD_BIT1;
      mode_after = MODE_RECEIVING;
    end else if (is_stop) begin
      kind       = CMD_STOP;
      mode_after = MODE_IDLE;
    end else begin
      kind       = CMD_ERROR;
      mode_after = MODE_IDLE;
    end
  end

  always_comb begin
    cmd_wr   = 1'b0;
    cmd_data = '{kind: kind, width: width, mode: mode_after};
    unique case (in_item.operation)
      OP_RISE: cmd_wr = accept;
      OP_SOFT: begin
        cmd_wr   = accept;
        cmd_data = '{kind: CMD_CLEAR, width: width, mode: MODE_IDLE};
      end
      default: cmd_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_min   <= 16'd58;
      sync_max   <= 16'd66;
      zero_min   <= 16'd3;
      zero_max   <= 16'd5;
      one_min    <= 16'd1;
      one_limit  <= 16'd3;
      stop_min   <= 16'd20;
      fall_stamp <= '0;
      mode       <= MODE_IDLE;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_SYNC_MIN:  sync_min  <= cfg_data;
          REG_SYNC_MAX:  sync_max  <= cfg_data;
          REG_ZERO_MIN:  zero_min  <= cfg_data;
          REG_ZERO_MAX:  zero_max  <= cfg_data;
          REG_ONE_MIN:   one_min   <= cfg_data;
          REG_ONE_LIMIT: one_limit <= cfg_data;
          REG_STOP_MIN:  stop_min  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        unique case (in_item.operation)
          OP_FALL: fall_stamp <= in_item.stamp_ms;
          OP_RISE: begin
            mode <= mode_after;
            // an error drops back as a soft reset does
            if (kind == CMD_ERROR) fall_stamp <= '0;
          end
          OP_SOFT: begin
            mode       <= MODE_IDLE;
            fall_stamp <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/pwfr_cmd_fifo.sv @@
// Short command queue that decouples the classifier from the frame engine.
// Depends on pwfr_pkg for the command type and depth.
`default_nettype none

module pwfr_cmd_fifo
  import pwfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output cmd_t      rd_data,
  output logic      empty
);

  cmd_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full    = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr_en |-> !full)
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd_en |-> !empty)
    else $error("command queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("command queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("command queue pointers disagree with count");

endmodule

`default_nettype wire

@@ rtl/pwfr_back.sv @@
// Frame engine: bit store, counters, result item build and frame byte runs.
// Depends on pwfr_pkg; drains the command queue into the output register.
`default_nettype none

module pwfr_back
  import pwfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_empty,
  input  wire cmd_t cmd,
  output logic      cmd_rd,
  input  wire logic pop,
  output logic      out_valid,
  output out_item_t out_item
);

  typedef enum logic {B_IDLE, B_EMIT} bstate_t;

  bstate_t           state;
  logic [7:0]        frame_store [STORE_BYTES];
  logic [BIT_W-1:0]  bit_total;
  logic [31:0]       frame_counter, error_counter;
  logic [IDX_W-1:0]  emit_idx;
  logic [BYTE_W-1:0] emit_bytes;
  logic [31:0]       emit_width;
  mode_t             emit_mode;

  logic              slot_free, bit_full, emit_last, load_out;
  logic [BIT_W-1:0]  bits_inc;
  logic [BYTE_W-1:0] bytes_now;
  out_item_t         cmd_item, emit_item;

  assign slot_free = !out_valid || pop;
  assign cmd_rd    = (state == B_IDLE) && !cmd_empty && slot_free;
  assign bit_full  = (bit_total == BIT_W'(MAX_FRAME_BITS));
  assign bits_inc  = bit_total + 1'b1;
  assign bytes_now = bytes_for_bits(bit_total);
  assign emit_last = (emit_bytes == '0) ||
                     ((BYTE_W'(emit_idx) + BYTE_W'(1)) == emit_bytes);
  // Output register takes a new item this cycle
  assign load_out  = (state == B_EMIT) ? slot_free
                   : (cmd_rd && (cmd.kind != CMD_STOP) && (cmd.kind != CMD_CLEAR));

  // Single result item for every command but stop and clear
  always_comb begin
    cmd_item = '{status: ST_IGNORED, pulse_width_ms: cmd.width, data_byte: 8'd0,
                 byte_index: 6'd0, byte_total: 7'(bytes_now), bits_held: 10'(bit_total),
                 frames_done: frame_counter, errors_seen: error_counter,
                 rx_mode: cmd.mode, last: 1'b1};
    unique case (cmd.kind)
      CMD_SYNC: begin
        cmd_item.status     = ST_SYNCED;
        cmd_item.byte_total = '0;
        cmd_item.bits_held  = '0;
      end
      CMD_BIT0, CMD_BIT1: begin
        if (bit_full) begin
          cmd_item.status = ST_DROPPED;
        end else begin
          cmd_item.status     = ST_STORED;
          cmd_item.bits_held  = 10'(bits_inc);
          cmd_item.byte_total = 7'(bytes_for_bits(bits_inc));
        end
      end
      CMD_ERROR: begin
        cmd_item.status      = ST_ERROR;
        cmd_item.byte_total  = '0;
        cmd_item.bits_held   = '0;
        cmd_item.errors_seen = error_counter + 1'b1;
      end
      default: cmd_item.status = ST_IGNORED;
    endcase
  end

  always_comb begin
    emit_item = '{status: ST_BYTE, pulse_width_ms: emit_width,
                  data_byte: (emit_bytes == '0) ? 8'd0 : frame_store[emit_idx],
                  byte_index: 6'(emit_idx), byte_total: 7'(emit_bytes),
                  bits_held: 10'(bit_total), frames_done: frame_counter,
                  errors_seen: error_counter, rx_mode: emit_mode, last: emit_last};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      bit_total     <= '0;
      frame_counter <= '0;
      error_counter <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < STORE_BYTES; i++) frame_store[i] <= '0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (cmd_rd) begin
            unique case (cmd.kind)
              CMD_SYNC, CMD_ERROR, CMD_CLEAR: begin
                bit_total <= '0;
                for (int i = 0; i < STORE_BYTES; i++) frame_store[i] <= '0;
                if (cmd.kind == CMD_ERROR) error_counter <= error_counter + 1'b1;
              end
              CMD_BIT0, CMD_BIT1: begin
                if (!bit_full) begin
                  frame_store[bit_total[IDX_W+2:3]][~bit_total[2:0]] <= (cmd.kind == CMD_BIT1);
                  bit_total <= bits_inc;
                end
              end
              CMD_STOP: begin
                frame_counter <= frame_counter + 1'b1;
                emit_width    <= cmd.width;
                emit_mode     <= cmd.mode;
                emit_bytes    <= bytes_now;
                emit_idx      <= '0;
                state         <= B_EMIT;
              end
              default: ;
            endcase
            if (cmd.kind != CMD_STOP && cmd.kind != CMD_CLEAR) out_item <= cmd_item;
          end
        end
        B_EMIT: begin
          // one frame byte per free output slot
          if (slot_free) begin
            out_item <= emit_item;
            emit_idx <= emit_idx + 1'b1;
            if (emit_last) state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/pulse_width_frame_receiver.sv @@
// Top level of the pulse width frame receiver: front, command queue, back.
// Depends on pwfr_pkg, pwfr_front, pwfr_cmd_fifo and pwfr_back.
//
// Usage:
//  - Input channel (push/full, in_item): falling edge, rising edge and soft
//    reset events with millisecond timestamps. An item is taken when push is
//    high and full is low. Falling edges, soft resets and unused codes are
//    taken every cycle while the command queue has room.
//  - Result channel (empty/pop, out_item): the oldest result sits on out_item
//    while empty is low; pop takes it. last marks the final item of an event.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): seven 16-bit
//    thresholds, always ready; write only while the block is quiet.
//  - A rising edge is queued, then registered as its result. Throughput:
//    one item per cycle while the queue has room and pop keeps up; a stop
//    pulse holds the engine while it emits its bytes (up to STORE_BYTES).
//  - A four-entry command queue sits between classifier and frame engine, so
//    when the receiver stalls on pop, input is still taken until it fills.
//  - Reset (rst, synchronous): thresholds return to defaults, counters, frame
//    store and mode clear at once; no sweep, the block is ready next cycle.
`default_nettype none

module pulse_width_frame_receiver
  import pwfr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire in_item_t             in_item,
  output logic                      empty,
  input  wire logic                 pop,
  output out_item_t                 out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  logic accept;
  logic cmd_wr, cmd_rd, cmd_empty;
  cmd_t cmd_in, cmd_out;
  logic out_valid;

  // Take an item whenever the command queue has room
  assign accept    = push && !full;
  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;

  pwfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_item   (in_item),
    .cfg_wr    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_wr    (cmd_wr),
    .cmd_data  (cmd_in)
  );

  pwfr_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_rd),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  // Pop only counts when a result is actually on the ports
  pwfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_rd    (cmd_rd),
    .pop       (pop && out_valid),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

@@ tb/sv/pwfr_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker of the pulse width frame receiver: decodes every accepted event
// on its own and compares each popped result item, field by field, in order.
// Depends on pwfr_pkg for the item types, codes, register indexes and frame size.

module pwfr_result_checker
  import pwfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  in_item_t             in_item,
  input  logic                 empty,
  input  logic                 pop,
  input  out_item_t            out_item,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int unsigned          outstanding,
  output int unsigned          mismatches
);

  localparam int NUM_REGS     = 7;
  localparam int REPORT_LIMIT = 10;

  logic [15:0] thr [NUM_REGS];
  logic [31:0] fall_time;
  logic [7:0]  frame_bytes [STORE_BYTES];
  int unsigned held_bits;
  mode_t       rx_state;
  logic [31:0] frame_tally;
  logic [31:0] error_tally;
  int unsigned fail_tally = 0;
  out_item_t   awaited_q [$];

  task automatic clear_frame();
    for (int i = 0; i < STORE_BYTES; i++) frame_bytes[i] = 8'h00;
    held_bits = 0;
  endtask

  task automatic soft_clear();
    clear_frame();
    rx_state  = MODE_IDLE;
    fall_time = 32'd0;
  endtask

  task automatic reset_model();
    thr[REG_SYNC_MIN]  = 16'd58;
    thr[REG_SYNC_MAX]  = 16'd66;
    thr[REG_ZERO_MIN]  = 16'd3;
    thr[REG_ZERO_MAX]  = 16'd5;
    thr[REG_ONE_MIN]   = 16'd1;
    thr[REG_ONE_LIMIT] = 16'd3;
    thr[REG_STOP_MIN]  = 16'd20;
    frame_tally = 32'd0;
    error_tally = 32'd0;
    soft_clear();
  endtask

  // Result fields that reflect the state after the step
  function automatic out_item_t make_result(logic [2:0] status, logic [31:0] width,
                                            logic [7:0] data, logic [5:0] index,
                                            logic is_last);
    out_item_t r;
    r.status         = status;
    r.pulse_width_ms = width;
    r.data_byte      = data;
    r.byte_index     = index;
    r.byte_total     = 7'((held_bits + 7) >> 3);
    r.bits_held      = 10'(held_bits);
    r.frames_done    = frame_tally;
    r.errors_seen    = error_tally;
    r.rx_mode        = rx_state;
    r.last           = is_last;
    return r;
  endfunction

  // MSB first; drop once the store is full
  task automatic store_bit(input logic value, output logic [2:0] st);
    int unsigned pos;
    int unsigned shift;
    if (held_bits >= MAX_FRAME_BITS || (held_bits >> 3) >= STORE_BYTES) begin
      st = ST_DROPPED;
    end else begin
      pos   = held_bits >> 3;
      shift = 7 - (held_bits & 7);
      frame_bytes[pos][shift] = value;
      held_bits++;
      st = ST_STORED;
    end
  endtask

  task automatic decode_event(input in_item_t ev);
    logic [31:0] w;
    logic [2:0]  st;
    int unsigned nbytes;
    case (ev.operation)
      OP_FALL: fall_time = ev.stamp_ms;
      OP_SOFT: soft_clear();
      OP_RISE: begin
        w = ev.stamp_ms - fall_time;
        if (w >= thr[REG_SYNC_MIN] && w <= thr[REG_SYNC_MAX]) begin
          clear_frame();
          rx_state = MODE_SYNCED;
          awaited_q.push_back(make_result(ST_SYNCED, w, 8'h00, 6'd0, 1'b1));
        end else if (rx_state == MODE_IDLE) begin
          awaited_q.push_back(make_result(ST_IGNORED, w, 8'h00, 6'd0, 1'b1));
        end else if (w >= thr[REG_ZERO_MIN] && w <= thr[REG_ZERO_MAX]) begin
          store_bit(1'b0, st);
          rx_state = MODE_RECEIVING;
          awaited_q.push_back(make_result(st, w, 8'h00, 6'd0, 1'b1));
        end else if (w >= thr[REG_ONE_MIN] && w < thr[REG_ONE_LIMIT]) begin
          store_bit(1'b1, st);
          rx_state = MODE_RECEIVING;
          awaited_q.push_back(make_result(st, w, 8'h00, 6'd0, 1'b1));
        end else if (w >= thr[REG_STOP_MIN]) begin
          frame_tally++;
          rx_state = MODE_IDLE;
          nbytes = (held_bits + 7) >> 3;
          if (nbytes > STORE_BYTES) nbytes = STORE_BYTES;
          if (nbytes == 0) begin
            awaited_q.push_back(make_result(ST_BYTE, w, 8'h00, 6'd0, 1'b1));
          end else begin
            for (int i = 0; i < nbytes; i++)
              awaited_q.push_back(make_result(ST_BYTE, w, frame_bytes[i], 6'(i),
                                              i == nbytes - 1));
          end
        end else begin
          error_tally++;
          soft_clear();
          awaited_q.push_back(make_result(ST_ERROR, w, 8'h00, 6'd0, 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  function automatic string describe(out_item_t r);
    return {$sformatf("st %0d w %0d byte %0d idx %0d total %0d ",
                      r.status, r.pulse_width_ms, r.data_byte, r.byte_index,
                      r.byte_total),
            $sformatf("bits %0d frames %0d errors %0d mode %0d last %0d",
                      r.bits_held, r.frames_done, r.errors_seen, r.rx_mode, r.last)};
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    logic      bad;
    if (rst) begin
      reset_model();
      awaited_q.delete();
    end else begin
      if (pop && !empty) begin
        if (awaited_q.size() == 0) begin
          fail_tally++;
          if (fail_tally <= REPORT_LIMIT)
            $display("%0t: result item with none expected: %s", $realtime,
                     describe(out_item));
        end else begin
          want = awaited_q.pop_front();
          bad = (want.status         !== out_item.status)
             || (want.pulse_width_ms !== out_item.pulse_width_ms)
             || (want.data_byte      !== out_item.data_byte)
             || (want.byte_index     !== out_item.byte_index)
             || (want.byte_total     !== out_item.byte_total)
             || (want.bits_held      !== out_item.bits_held)
             || (want.frames_done    !== out_item.frames_done)
             || (want.errors_seen    !== out_item.errors_seen)
             || (want.rx_mode        !== out_item.rx_mode)
             || (want.last           !== out_item.last);
          if (bad) begin
            fail_tally++;
            if (fail_tally <= REPORT_LIMIT) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(out_item));
            end
          end
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS) thr[cfg_index] = cfg_data;
      if (push && !full) decode_event(in_item);
    end
    outstanding <= awaited_q.size();
    mismatches  <= fail_tally;
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the pulse width frame receiver testbench: clock, reset, event stimulus,
// threshold writes and the verdict. Depends on pwfr_pkg, the receiver and
// pwfr_result_checker, which predicts and compares every result item.

module testbench
  import pwfr_pkg::*;
();

  localparam int CLK_HALF          = 6;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int DRAIN_CYCLES      = 24;
  localparam int NUM_SEGMENTS      = 6;
  localparam int ITEMS_PER_SEGMENT = 30;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef logic [6:0][15:0] thr_set_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 push      = 1'b0;
  in_item_t             in_item   = '0;
  logic                 pop       = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = '0;
  logic                 full;
  logic                 empty;
  logic                 cfg_ready;
  out_item_t            out_item;
  int unsigned          outstanding;
  int unsigned          mismatches;

  // Idle and stall odds in percent, set per segment
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  // Thresholds as last written; only used to aim pulse widths at the classes
  thr_set_t    cur_thr;
  logic [31:0] now_ms;
  int unsigned sent_count;
  int unsigned cycle_count = 0;

  pulse_width_frame_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pwfr_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_item     (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Receiver side: pop at random, independent of empty
  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(99, 0) >= pop_stall_pct);
  end

  // Hard stop if the block hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  // Offer one item; hold it until an edge sees push high and full low.
  // Idle gaps go in front, so a following item keeps push high without a dip.
  task automatic send_event(input logic [1:0] op, input logic [31:0] ts);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= '{operation: op, stamp_ms: ts};
    do @(posedge clk); while (full);
    if (op != OP_UNUSED) sent_count++;
  endtask

  // One low pulse: falling edge now, rising edge width later, then a gap
  task automatic pulse(input logic [31:0] width);
    send_event(OP_FALL, now_ms);
    send_event(OP_RISE, now_ms + width);
    now_ms = now_ms + width + $urandom_range(40, 1);
  endtask

  function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi);
    return (hi >= lo) ? $urandom_range(hi, lo) : lo;
  endfunction

  function automatic logic [31:0] sync_width();
    return pick(cur_thr[REG_SYNC_MIN], cur_thr[REG_SYNC_MAX]);
  endfunction

  function automatic logic [31:0] bit_width();
    if ($urandom_range(1, 0) == 0)
      return pick(cur_thr[REG_ZERO_MIN], cur_thr[REG_ZERO_MAX]);
    if (cur_thr[REG_ONE_LIMIT] > cur_thr[REG_ONE_MIN])
      return pick(cur_thr[REG_ONE_MIN], cur_thr[REG_ONE_LIMIT] - 1);
    return cur_thr[REG_ONE_MIN];
  endfunction

  // Aim between the bit classes and stop; fall back to plain noise
  function automatic logic [31:0] error_width();
    if (cur_thr[REG_STOP_MIN] > cur_thr[REG_ZERO_MAX] + 1)
      return pick(cur_thr[REG_ZERO_MAX] + 1, cur_thr[REG_STOP_MIN] - 1);
    return $urandom_range(80, 0);
  endfunction

  // Well-formed frame: sync, data bits, stop
  task automatic send_frame(input int unsigned nbits);
    pulse(sync_width());
    repeat (nbits) pulse(bit_width());
    pulse(cur_thr[REG_STOP_MIN] + $urandom_range(30, 0));
  endtask

  // Frame cut short by a bad pulse, a soft reset or a fresh sync
  task automatic send_broken();
    pulse(sync_width());
    repeat ($urandom_range(4, 0)) pulse(bit_width());
    case ($urandom_range(2, 0))
      0:       pulse(error_width());
      1:       send_event(OP_SOFT, $urandom());
      default: pulse(sync_width());
    endcase
  endtask

  // Drop push, wait for every expected item, then let trailing events drain.
  // The first edge lets the checker count an item taken at the last edge.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_thresholds(input thr_set_t v);
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= v[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_thr = v;
  endtask

  function automatic thr_set_t segment_thresholds(int seg);
    thr_set_t v;
    case (seg)
      1: v = '0;                          // everything collapses onto width zero
      2: begin                            // wider, well separated classes
        v[REG_SYNC_MIN]  = 16'd100;
        v[REG_SYNC_MAX]  = 16'd130;
        v[REG_ZERO_MIN]  = 16'd10;
        v[REG_ZERO_MAX]  = 16'd16;
        v[REG_ONE_MIN]   = 16'd4;
        v[REG_ONE_LIMIT] = 16'd10;
        v[REG_STOP_MIN]  = 16'd40;
      end
      3: v = '1;                          // top of range
      4: begin                            // random, often overlapping or inverted
        for (int i = 0; i < 7; i++) v[i] = 16'($urandom_range(120, 0));
      end
      default: begin                      // power-on values
        v[REG_SYNC_MIN]  = 16'd58;
        v[REG_SYNC_MAX]  = 16'd66;
        v[REG_ZERO_MIN]  = 16'd3;
        v[REG_ZERO_MAX]  = 16'd5;
        v[REG_ONE_MIN]   = 16'd1;
        v[REG_ONE_LIMIT] = 16'd3;
        v[REG_STOP_MIN]  = 16'd20;
      end
    endcase
    return v;
  endfunction

  initial begin
    int unsigned kind;
    cur_thr = segment_thresholds(0);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, power-on thresholds
    sent_count = 0;
    send_event(OP_RISE, 32'd5);            // idle, fall time still zero: ignored
    send_event(OP_UNUSED, 32'hFFFF_FFFF);  // unused code: no item
    now_ms = 32'h8000_0000;
    pulse(58);                             // sync at its lower bound
    pulse(3);                              // bit zero, lower bound
    pulse(5);                              // bit zero, upper bound
    pulse(1);                              // bit one, lower bound
    pulse(2);                              // bit one, just below its limit
    pulse(20);                             // stop at its bound: one frame byte
    pulse(66);                             // sync at its upper bound
    pulse(10);                             // between classes: error
    send_event(OP_SOFT, 32'h0000_0000);
    send_event(OP_FALL, 32'hFFFF_FFFF);    // sync across the timestamp wrap
    send_event(OP_RISE, 32'h0000_0040);
    send_event(OP_FALL, 32'h0000_0050);    // rise before fall: huge width, stop
    send_event(OP_RISE, 32'h0000_0010);    // of an empty frame

    // Random part: one threshold set and one idle pattern per segment
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      settle();
      write_thresholds(segment_thresholds(seg));
      case (seg % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 86; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 86; end
        default: begin send_idle_pct = 20; pop_stall_pct = 20; end
      endcase
      now_ms = ($urandom_range(3, 0) == 0) ? 32'hFFFF_FF00 + $urandom_range(255, 0)
                                           : $urandom();
      sent_count = 0;
      // Overfill the store once so bits get dropped
      if (seg == 0) send_frame(MAX_FRAME_BITS + 2);
      while (sent_count < ITEMS_PER_SEGMENT) begin
        kind = $urandom_range(9, 0);
        if (kind < 7) begin
          if ($urandom_range(39, 0) == 0)
            send_frame($urandom_range(MAX_FRAME_BITS + 4, MAX_FRAME_BITS - 4));
          else
            send_frame($urandom_range(12, 0));
        end else if (kind == 7) begin
          send_event(2'($urandom_range(3, 0)), $urandom());
        end else if (kind == 8) begin
          send_broken();
        end else begin
          pulse($urandom_range(80, 0));
        end
      end
    end

    settle();
    if (mismatches == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

@@ pulse_width_frame_receiver.f @@
rtl/pwfr_pkg.sv
rtl/pwfr_front.sv
rtl/pwfr_cmd_fifo.sv
rtl/pwfr_back.sv
rtl/pulse_width_frame_receiver.sv
tb/sv/pwfr_result_checker.sv
tb/sv/testbench.sv
